// ===== sv/chth_pkg.sv =====
`timescale 1ns / 1ps

package chth_pkg;

  localparam int BUCKETS_DEF = 257;
  localparam int ENTRIES_DEF = 256;

  localparam int KEY_W   = 32;
  localparam int VALUE_W = 32;
  localparam int OP_W    = 2;
  localparam int STAT_W  = 2;
  localparam int TOTAL_W = 9;

  localparam logic [OP_W-1:0] OP_GET    = 2'd0;
  localparam logic [OP_W-1:0] OP_PUT    = 2'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

  localparam logic [STAT_W-1:0] ST_FOUND  = 2'd0;
  localparam logic [STAT_W-1:0] ST_ABSENT = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL   = 2'd2;
  localparam logic [STAT_W-1:0] ST_ZERO   = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]    operation;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] new_value;
  } request_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [VALUE_W-1:0] old_value;
    logic [TOTAL_W-1:0] entry_total;
  } result_t;

endpackage

// ===== sv/chth_ram.sv =====
`timescale 1ns / 1ps

module chth_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/chained_hash_table.sv =====
`timescale 1ns / 1ps

// Key/value table with separate chaining over a pool of ENTRIES nodes. A word
// is accepted when start is high and busy is low; its result appears on
// result for exactly one cycle with done high, and cannot be held off. A zero
// key is answered from the idle state without a lookup. Any other key first
// forms its bucket (key >> 2) mod BUCKETS by reciprocal multiplication on one
// shared multiplier, then reads the bucket head and compares chain nodes one
// at a time, each a read of the node memories, before it finishes. After
// reset the block stays busy while it clears the bucket heads and builds the
// free list.
module chained_hash_table #(
  parameter int BUCKETS = chth_pkg::BUCKETS_DEF,
  parameter int ENTRIES = chth_pkg::ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  chth_pkg::request_t request,
  output logic               busy,
  output logic               done,
  output chth_pkg::result_t  result
);

  localparam int PW   = $clog2(ENTRIES + 1);
  localparam int AW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int BW   = $clog2(BUCKETS);
  localparam int MAXD = (BUCKETS > ENTRIES) ? BUCKETS : ENTRIES;
  localparam int CW   = $clog2(MAXD);
  localparam int XW   = chth_pkg::KEY_W - 2;
  localparam int MSH  = XW + BW;
  localparam int PRW  = 2 * chth_pkg::KEY_W;

  // quotient by reciprocal: exact for every shifted key below 2^XW
  localparam logic [63:0] RECIP_FULL =
      ((64'd1 << MSH) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS);

  localparam logic [PW-1:0]               NIL      = PW'(ENTRIES);
  localparam logic [chth_pkg::KEY_W-1:0]  BK       = chth_pkg::KEY_W'(BUCKETS);
  localparam logic [chth_pkg::KEY_W-1:0]  RECIP    = RECIP_FULL[chth_pkg::KEY_W-1:0];
  localparam logic [CW-1:0]               CLR_LAST = CW'(MAXD - 1);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_MOD   = 4'd2;
  localparam logic [3:0] S_HEAD  = 4'd3;
  localparam logic [3:0] S_HWAIT = 4'd4;
  localparam logic [3:0] S_WALK  = 4'd5;
  localparam logic [3:0] S_CMP   = 4'd6;
  localparam logic [3:0] S_HIT   = 4'd7;
  localparam logic [3:0] S_REM2  = 4'd8;
  localparam logic [3:0] S_MISS  = 4'd9;
  localparam logic [3:0] S_ALLOC = 4'd10;

  logic [3:0]                     state;
  logic [CW-1:0]                  clr;
  logic [chth_pkg::OP_W-1:0]      op;
  logic [chth_pkg::KEY_W-1:0]     key_r;
  logic [chth_pkg::VALUE_W-1:0]   val_r;
  logic [chth_pkg::KEY_W-1:0]     sh;
  logic [chth_pkg::KEY_W-1:0]     quot;
  logic                           mstep;
  logic [BW-1:0]                  rem;
  logic [PW-1:0]                  p;
  logic [PW-1:0]                  prev;
  logic [PW-1:0]                  headv;
  logic [PW-1:0]                  steps;
  logic [PW-1:0]                  free_head;
  logic [PW-1:0]                  live;
  logic [PW-1:0]                  cur_next;
  logic [chth_pkg::VALUE_W-1:0]   cur_val;

  logic [chth_pkg::KEY_W-1:0]     mul_a;
  logic [chth_pkg::KEY_W-1:0]     mul_b;
  logic [PRW-1:0]                 mul_p;
  logic [chth_pkg::KEY_W-1:0]     diff;

  logic                           bh_we;
  logic [BW-1:0]                  bh_waddr;
  logic [PW-1:0]                  bh_wdata;
  logic [PW-1:0]                  bh_rdata;
  logic                           nk_we;
  logic                           nv_we;
  logic                           nn_we;
  logic [AW-1:0]                  kv_waddr;
  logic [AW-1:0]                  nn_waddr;
  logic [PW-1:0]                  nn_wdata;
  logic [AW-1:0]                  n_raddr;
  logic [chth_pkg::KEY_W-1:0]     nk_rdata;
  logic [chth_pkg::VALUE_W-1:0]   nv_rdata;
  logic [PW-1:0]                  nn_rdata;

  assign busy = (state != S_IDLE);

  // shared multiplier: key times reciprocal, then quotient times bucket count
  assign mul_a = mstep ? quot : sh;
  assign mul_b = mstep ? BK : RECIP;
  assign mul_p = PRW'(mul_a) * PRW'(mul_b);
  assign diff  = sh - mul_p[chth_pkg::KEY_W-1:0];

  always_comb begin
    bh_we    = 1'b0;
    bh_waddr = rem;
    bh_wdata = NIL;
    nk_we    = 1'b0;
    nv_we    = 1'b0;
    nn_we    = 1'b0;
    kv_waddr = p[AW-1:0];
    nn_waddr = p[AW-1:0];
    nn_wdata = free_head;
    n_raddr  = p[AW-1:0];
    unique case (state)
      S_CLEAR: begin
        bh_we    = (int'(clr) < BUCKETS);
        bh_waddr = clr[BW-1:0];
        nn_we    = (int'(clr) < ENTRIES);
        nn_waddr = clr[AW-1:0];
        nn_wdata = PW'(clr) + PW'(1);
      end
      S_HIT: begin
        if (op == chth_pkg::OP_PUT) begin
          nv_we = 1'b1;
        end else if (op == chth_pkg::OP_REMOVE) begin
          if (prev < NIL) begin
            nn_we    = 1'b1;
            nn_waddr = prev[AW-1:0];
            nn_wdata = cur_next;
          end else begin
            bh_we    = 1'b1;
            bh_wdata = cur_next;
          end
        end
      end
      S_REM2: begin
        nn_we = 1'b1;
      end
      S_MISS: begin
        n_raddr = free_head[AW-1:0];
      end
      S_ALLOC: begin
        nk_we    = 1'b1;
        nv_we    = 1'b1;
        kv_waddr = free_head[AW-1:0];
        nn_we    = 1'b1;
        nn_waddr = free_head[AW-1:0];
        nn_wdata = headv;
        bh_we    = 1'b1;
        bh_wdata = free_head;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr       <= '0;
      free_head <= '0;
      live      <= '0;
      done      <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr <= clr + 1'b1;
          if (clr == CLR_LAST) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            op    <= request.operation;
            key_r <= request.key;
            val_r <= request.new_value;
            if (request.key == '0) begin
              result <= '{status: chth_pkg::ST_ZERO, old_value: '0,
                          entry_total: chth_pkg::TOTAL_W'(live)};
              done   <= 1'b1;
            end else begin
              sh    <= {2'b00, request.key[chth_pkg::KEY_W-1:2]};
              mstep <= 1'b0;
              state <= S_MOD;
            end
          end
        end
        S_MOD: begin
          if (!mstep) begin
            quot  <= chth_pkg::KEY_W'(mul_p >> MSH);
            mstep <= 1'b1;
          end else begin
            rem   <= diff[BW-1:0];
            state <= S_HEAD;
          end
        end
        S_HEAD: begin
          state <= S_HWAIT;
        end
        S_HWAIT: begin
          p     <= bh_rdata;
          headv <= bh_rdata;
          prev  <= NIL;
          steps <= '0;
          state <= S_WALK;
        end
        S_WALK: begin
          if (p >= NIL || steps == NIL) begin
            state <= S_MISS;
          end else begin
            state <= S_CMP;
          end
        end
        S_CMP: begin
          if (nk_rdata == key_r) begin
            cur_next <= nn_rdata;
            cur_val  <= nv_rdata;
            state    <= S_HIT;
          end else begin
            prev  <= p;
            p     <= nn_rdata;
            steps <= steps + 1'b1;
            state <= S_WALK;
          end
        end
        S_HIT: begin
          if (op == chth_pkg::OP_REMOVE) begin
            state <= S_REM2;
          end else begin
            result <= '{status: chth_pkg::ST_FOUND, old_value: cur_val,
                        entry_total: chth_pkg::TOTAL_W'(live)};
            done   <= 1'b1;
            state  <= S_IDLE;
          end
        end
        S_REM2: begin
          free_head <= p;
          if (live != '0) begin
            live <= live - 1'b1;
          end
          result <= '{status: chth_pkg::ST_FOUND, old_value: cur_val,
                      entry_total: chth_pkg::TOTAL_W'((live != '0) ? live - 1'b1 : live)};
          done   <= 1'b1;
          state  <= S_IDLE;
        end
        S_MISS: begin
          if (op == chth_pkg::OP_PUT && free_head < NIL) begin
            state <= S_ALLOC;
          end else begin
            result <= '{status: (op == chth_pkg::OP_PUT) ? chth_pkg::ST_FULL
                                                          : chth_pkg::ST_ABSENT,
                        old_value: '0, entry_total: chth_pkg::TOTAL_W'(live)};
            done   <= 1'b1;
            state  <= S_IDLE;
          end
        end
        S_ALLOC: begin
          free_head <= nn_rdata;
          live      <= live + 1'b1;
          result    <= '{status: chth_pkg::ST_ABSENT, old_value: '0,
                         entry_total: chth_pkg::TOTAL_W'(live + 1'b1)};
          done      <= 1'b1;
          state     <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  chth_ram #(.WIDTH(PW), .DEPTH(BUCKETS)) u_bucket_head (
    .clk   (clk),
    .we    (bh_we),
    .waddr (bh_waddr),
    .wdata (bh_wdata),
    .raddr (rem),
    .rdata (bh_rdata)
  );

  chth_ram #(.WIDTH(chth_pkg::KEY_W), .DEPTH(ENTRIES)) u_node_key (
    .clk   (clk),
    .we    (nk_we),
    .waddr (kv_waddr),
    .wdata (key_r),
    .raddr (n_raddr),
    .rdata (nk_rdata)
  );

  chth_ram #(.WIDTH(chth_pkg::VALUE_W), .DEPTH(ENTRIES)) u_node_value (
    .clk   (clk),
    .we    (nv_we),
    .waddr (kv_waddr),
    .wdata (val_r),
    .raddr (n_raddr),
    .rdata (nv_rdata)
  );

  chth_ram #(.WIDTH(PW), .DEPTH(ENTRIES)) u_node_next (
    .clk   (clk),
    .we    (nn_we),
    .waddr (nn_waddr),
    .wdata (nn_wdata),
    .raddr (n_raddr),
    .rdata (nn_rdata)
  );

`ifndef SYNTH
  a_live_bound: assert property (@(posedge clk) disable iff (rst)
    live <= NIL)
    else $error("live count above pool size");

  a_done_on_finish: assert property (@(posedge clk) disable iff (rst)
    ($past(state) != S_IDLE && $past(state) != S_CLEAR && state == S_IDLE) |-> done)
    else $error("operation finished without a result strobe");

  a_full_pool: assert property (@(posedge clk) disable iff (rst)
    (done && result.status == chth_pkg::ST_FULL) |-> (free_head == NIL))
    else $error("pool full reported with a free node");

  a_cmp_valid_node: assert property (@(posedge clk) disable iff (rst)
    (state == S_CMP) |-> (p < NIL))
    else $error("compare on a null node");
`endif

endmodule
